[src/assert_macros.svh]
// assertion macros shared by the rtl files
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg)
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

[src/pcms_pkg.sv]
// types, codes and helper functions of the periodic can message scheduler
// no dependencies
package pcms_pkg;

    localparam int SLOTS    = 8;
    localparam int CHANNELS = 8;
    localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic [31:0] STD_ID_MASK = 32'h0000_07FF;
    localparam logic [3:0]  MAX_LEN     = 4'd8;
    localparam int          BYTES       = 8;

    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_STOP  = 2'd2;

    localparam logic KIND_REPLY = 1'b0;
    localparam logic KIND_FRAME = 1'b1;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_BAD_CHANNEL = 2'd1,
        ST_LIMIT       = 2'd2,
        ST_BAD_ID      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        IDLE,
        START,
        STOP_SCAN,
        TICK_SCAN,
        EMIT
    } state_t;

    function automatic logic chan_ok(input logic [7:0] mask, input logic [7:0] ch);
        logic [2:0] bit_idx;
        bit_idx = 3'(ch - 8'd1);
        return (ch != 8'd0) && (ch <= 8'(CHANNELS)) && mask[bit_idx];
    endfunction

    function automatic logic [3:0] clamp_len(input logic [3:0] len);
        return (len > MAX_LEN) ? MAX_LEN : len;
    endfunction

    // keep the first len bytes from the top, zero the rest
    function automatic logic [63:0] keep_bytes(input logic [63:0] data, input logic [3:0] len);
        logic [63:0] res;
        res = '0;
        for (int b = 0; b < BYTES; b++) begin
            if (4'(b) < len) begin
                res[63 - 8*b -: 8] = data[63 - 8*b -: 8];
            end
        end
        return res;
    endfunction

endpackage

[src/periodic_can_message_scheduler.sv]
// periodic can transmit scheduler: slot table, one shared elapsed-time compare under a sequencer
// start replies come from START; a stop scans slots until id and channel match or the last slot;
// a tick scans every slot, then EMIT sends the due frames in slot order, held by output stalls
// one request at a time: s_ready is high only in IDLE, so no new request is taken mid-scan
// reset: synchronous active-low aresetn clears control, slot valid bits, mask, time (0), id (1)
// depends on pcms_pkg and assert_macros.svh; slot table contents are not cleared
`include "assert_macros.svh"

module periodic_can_message_scheduler
    import pcms_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [7:0]  s_channel_id,
    input  logic [31:0] s_can_id,
    input  logic        s_extended,
    input  logic [63:0] s_payload,
    input  logic [3:0]  s_payload_len,
    input  logic [15:0] s_interval,
    input  logic [31:0] s_msg_id,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [1:0]  m_status,
    output logic [31:0] m_assigned_id,
    output logic [31:0] m_frame_id,
    output logic        m_frame_extended,
    output logic [63:0] m_frame_payload,
    output logic [3:0]  m_frame_len,
    output logic        m_last
);

    localparam logic [SLOT_W-1:0] IDX_LAST = SLOT_W'(SLOTS - 1);

    state_t              state_reg, state_next;
    logic [SLOT_W-1:0]   idx_reg, idx_next;
    logic [SLOTS-1:0]    due_reg, due_next;
    logic [SLOTS-1:0]    active_reg, active_next;
    logic [31:0]         now_reg, now_next;
    logic [31:0]         next_id_reg, next_id_next;
    logic [7:0]          mask_reg;

    logic [7:0]          ch_reg;
    logic [31:0]         can_id_reg;
    logic                ext_reg;
    logic [63:0]         data_reg;
    logic [3:0]          len_reg;
    logic [15:0]         interval_reg;
    logic [31:0]         msg_id_reg;

    // slot table
    logic [31:0]         slot_msg_id_reg   [SLOTS];
    logic [7:0]          slot_channel_reg  [SLOTS];
    logic [15:0]         slot_interval_reg [SLOTS];
    logic [31:0]         slot_last_reg     [SLOTS];
    logic [31:0]         slot_fid_reg      [SLOTS];
    logic                slot_ext_reg      [SLOTS];
    logic [3:0]          slot_len_reg      [SLOTS];
    logic [63:0]         slot_data_reg     [SLOTS];

    logic                slot_we;
    logic [SLOT_W-1:0]   slot_widx;
    logic                last_we;
    logic [SLOT_W-1:0]   last_widx;

    logic [31:0]         rd_msg_id;
    logic [7:0]          rd_channel;
    logic [15:0]         rd_interval;
    logic [31:0]         rd_last;
    logic [31:0]         elapsed;
    logic                due_now;
    logic                stop_match;
    logic                idx_is_last;
    logic [SLOTS-1:0]    due_shift;
    logic                hi_due;

    logic                free_found;
    logic [SLOT_W-1:0]   free_idx;

    logic                out_free;
    logic                out_load;
    logic                out_kind;
    status_t             out_status;
    logic [31:0]         out_assigned_id;
    logic [31:0]         out_frame_id;
    logic                out_frame_ext;
    logic [63:0]         out_frame_payload;
    logic [3:0]          out_frame_len;
    logic                out_last;

    logic                m_valid_reg;
    logic                m_kind_reg;
    logic [1:0]          m_status_reg;
    logic [31:0]         m_assigned_id_reg;
    logic [31:0]         m_frame_id_reg;
    logic                m_frame_ext_reg;
    logic [63:0]         m_frame_payload_reg;
    logic [3:0]          m_frame_len_reg;
    logic                m_last_reg;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;

    // shared read port and compare unit
    assign rd_msg_id   = slot_msg_id_reg[idx_reg];
    assign rd_channel  = slot_channel_reg[idx_reg];
    assign rd_interval = slot_interval_reg[idx_reg];
    assign rd_last     = slot_last_reg[idx_reg];
    assign elapsed     = now_reg - rd_last;
    assign due_now     = active_reg[idx_reg] && (elapsed >= {16'd0, rd_interval})
                         && chan_ok(mask_reg, rd_channel);
    assign stop_match  = active_reg[idx_reg] && (rd_msg_id == msg_id_reg)
                         && (rd_channel == ch_reg);
    assign idx_is_last = (idx_reg == IDX_LAST);
    assign due_shift   = due_reg >> idx_reg;
    assign hi_due      = (due_shift >> 1) != '0;

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!active_reg[i]) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        state_next        = state_reg;
        idx_next          = idx_reg;
        due_next          = due_reg;
        active_next       = active_reg;
        now_next          = now_reg;
        next_id_next      = next_id_reg;
        s_ready           = 1'b0;
        slot_we           = 1'b0;
        slot_widx         = free_idx;
        last_we           = 1'b0;
        last_widx         = idx_reg;
        out_load          = 1'b0;
        out_kind          = KIND_REPLY;
        out_status        = ST_OK;
        out_assigned_id   = '0;
        out_frame_id      = '0;
        out_frame_ext     = 1'b0;
        out_frame_payload = '0;
        out_frame_len     = '0;
        out_last          = 1'b1;

        case (state_reg)
            IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    case (s_mode)
                        MODE_TICK: begin
                            now_next   = now_reg + 32'd1;
                            idx_next   = '0;
                            due_next   = '0;
                            state_next = TICK_SCAN;
                        end
                        MODE_START: begin
                            state_next = START;
                        end
                        MODE_STOP: begin
                            idx_next   = '0;
                            state_next = STOP_SCAN;
                        end
                        default: begin
                            state_next = IDLE;
                        end
                    endcase
                end
            end

            START: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (!chan_ok(mask_reg, ch_reg)) begin
                        out_status = ST_BAD_CHANNEL;
                    end else if (!free_found) begin
                        out_status = ST_LIMIT;
                    end else begin
                        out_status            = ST_OK;
                        out_assigned_id       = next_id_reg;
                        next_id_next          = next_id_reg + 32'd1;
                        active_next[free_idx] = 1'b1;
                        slot_we               = 1'b1;
                        last_we               = 1'b1;
                        last_widx             = free_idx;
                    end
                    state_next = IDLE;
                end
            end

            STOP_SCAN: begin
                if (stop_match || idx_is_last) begin
                    if (out_free) begin
                        out_load   = 1'b1;
                        out_status = stop_match ? ST_OK : ST_BAD_ID;
                        if (stop_match) begin
                            active_next[idx_reg] = 1'b0;
                        end
                        state_next = IDLE;
                    end
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            TICK_SCAN: begin
                due_next[idx_reg] = due_now;
                if (idx_is_last) begin
                    idx_next   = '0;
                    state_next = EMIT;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            EMIT: begin
                if (due_reg == '0) begin
                    state_next = IDLE;
                end else if (!due_reg[idx_reg]) begin
                    idx_next = idx_is_last ? '0 : idx_reg + 1'b1;
                end else if (out_free) begin
                    out_load          = 1'b1;
                    out_kind          = KIND_FRAME;
                    out_frame_id      = slot_fid_reg[idx_reg];
                    out_frame_ext     = slot_ext_reg[idx_reg];
                    out_frame_payload = slot_data_reg[idx_reg];
                    out_frame_len     = slot_len_reg[idx_reg];
                    out_last          = !hi_due;
                    due_next[idx_reg] = 1'b0;
                    last_we           = 1'b1;
                    idx_next          = idx_is_last ? '0 : idx_reg + 1'b1;
                    if (!hi_due) begin
                        state_next = IDLE;
                    end
                end
            end

            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            idx_reg     <= '0;
            due_reg     <= '0;
            active_reg  <= '0;
            now_reg     <= '0;
            next_id_reg <= 32'd1;
            mask_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            due_reg     <= due_next;
            active_reg  <= active_next;
            now_reg     <= now_next;
            next_id_reg <= next_id_next;
            if (cfg_valid && cfg_ready) begin
                mask_reg <= cfg_data;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // input capture
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            ch_reg       <= s_channel_id;
            can_id_reg   <= s_can_id;
            ext_reg      <= s_extended;
            data_reg     <= s_payload;
            len_reg      <= s_payload_len;
            interval_reg <= s_interval;
            msg_id_reg   <= s_msg_id;
        end
    end

    // slot table writes, frame fields stored ready to send
    always_ff @(posedge aclk) begin
        if (slot_we) begin
            slot_msg_id_reg[slot_widx]   <= next_id_reg;
            slot_channel_reg[slot_widx]  <= ch_reg;
            slot_interval_reg[slot_widx] <= interval_reg;
            slot_fid_reg[slot_widx]      <= ext_reg ? can_id_reg : (can_id_reg & STD_ID_MASK);
            slot_ext_reg[slot_widx]      <= ext_reg;
            slot_len_reg[slot_widx]      <= clamp_len(len_reg);
            slot_data_reg[slot_widx]     <= keep_bytes(data_reg, clamp_len(len_reg));
        end
        if (last_we) begin
            slot_last_reg[last_widx] <= now_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_kind_reg          <= out_kind;
            m_status_reg        <= out_status;
            m_assigned_id_reg   <= out_assigned_id;
            m_frame_id_reg      <= out_frame_id;
            m_frame_ext_reg     <= out_frame_ext;
            m_frame_payload_reg <= out_frame_payload;
            m_frame_len_reg     <= out_frame_len;
            m_last_reg          <= out_last;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_kind           = m_kind_reg;
    assign m_status         = m_status_reg;
    assign m_assigned_id    = m_assigned_id_reg;
    assign m_frame_id       = m_frame_id_reg;
    assign m_frame_extended = m_frame_ext_reg;
    assign m_frame_payload  = m_frame_payload_reg;
    assign m_frame_len      = m_frame_len_reg;
    assign m_last           = m_last_reg;

    `ASSERT_IMPL(a_idle_no_due, aclk, aresetn, state_reg == IDLE, due_reg == '0, "due slots left over at idle")
    `ASSERT_IMPL(a_reply_last, aclk, aresetn, m_valid && m_kind == KIND_REPLY, m_last, "reply without last")
    `ASSERT_IMPL(a_frame_fields, aclk, aresetn, m_valid && m_kind == KIND_FRAME, m_status == ST_OK && m_assigned_id == '0 && m_frame_len <= MAX_LEN, "bad frame fields")
    `ASSERT_NEXT(a_id_step, aclk, aresetn, out_load && out_assigned_id != '0, next_id_reg == $past(next_id_reg) + 32'd1, "message id not advanced on start")

endmodule
